/* hw/rtl/abts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abts_pkg: shared types and constants
// Constants and the result structs passed between the baseline and the
// window tracking stages of the ADC baseline and threshold block.
// ----------------------------------------------------------------------------
package abts_pkg;

  // Baseline is the mean of this many leading samples
  localparam int BASE_SAMPLES   = 64;
  localparam int BASE_SHIFT     = 6;
  // Window opens after this sample count
  localparam int WIN_START      = 66;
  // Window closes this many samples before the end of the waveform
  localparam int WIN_END_MARGIN = 6;
  // Trigger position is recorded only up to this margin
  localparam int POS_END_MARGIN = 7;
  // Sample counter saturates here
  localparam int COUNT_MAX      = 8191;

  localparam int SAMPLE_W = 12;
  localparam int CORR_W   = 13;
  localparam int COUNT_W  = 13;
  localparam int CFG_W    = 12;
  localparam int OUT_W    = 72;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_THRESHOLD       = 1'b0,
    REG_WAVEFORM_LENGTH = 1'b1
  } cfg_reg_t;

  // Per-sample result of the baseline stage
  typedef struct packed {
    logic                     trig_pos;
    logic                     trig_neg;
    logic signed [CORR_W-1:0] corrected;
    logic                     ready;
    logic [COUNT_W-1:0]       count;
  } base_res_t;

  // Window tracking result after this sample
  typedef struct packed {
    logic                     keep;
    logic [11:0]              keep_position;
    logic signed [CORR_W-1:0] keep_value;
    logic [11:0]              peak_pos;
    logic signed [CORR_W-1:0] peak_neg;
  } peak_res_t;

endpackage

/* hw/rtl/abts_base.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abts_base: baseline accumulator and threshold compare
// Counts samples, sums the first 64 into a baseline, subtracts it from later
// samples and compares the corrected value against +/- threshold.
// ----------------------------------------------------------------------------
module abts_base (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  step,
  input  logic                                  restart,
  input  logic signed [abts_pkg::SAMPLE_W-1:0]  sample,
  input  logic [abts_pkg::CFG_W-1:0]            threshold,
  output abts_pkg::base_res_t                   res
);

  logic [abts_pkg::COUNT_W-1:0]          sample_count;
  logic [abts_pkg::COUNT_W-1:0]          sample_count_next;
  logic [6:0]                            base_count;
  logic [6:0]                            base_count_next;
  logic signed [18:0]                    base_sum;
  logic signed [18:0]                    base_sum_next;
  logic signed [11:0]                    base_level;
  logic signed [11:0]                    base_level_next;

  logic [abts_pkg::COUNT_W-1:0]          count_cur;
  logic [6:0]                            bcount_cur;
  logic signed [18:0]                    sum_cur;
  logic signed [11:0]                    level_cur;
  logic signed [18:0]                    sum_adj;
  logic signed [abts_pkg::CORR_W-1:0]    corrected;
  logic signed [13:0]                    corr_ext;
  logic signed [13:0]                    thr_pos;
  logic signed [13:0]                    thr_neg;

  // Restart clears the state seen by this sample
  always_comb begin
    count_cur  = restart ? '0 : sample_count;
    bcount_cur = restart ? '0 : base_count;
    sum_cur    = restart ? '0 : base_sum;
    level_cur  = restart ? '0 : base_level;
  end

  // Advance the counters, accumulate and finish the baseline
  always_comb begin
    if (count_cur < abts_pkg::COUNT_W'(abts_pkg::COUNT_MAX)) begin
      sample_count_next = count_cur + 1'b1;
    end else begin
      sample_count_next = count_cur;
    end
    base_sum_next   = sum_cur;
    base_count_next = bcount_cur;
    base_level_next = level_cur;
    sum_adj         = '0;
    corrected       = '0;
    if (bcount_cur < 7'(abts_pkg::BASE_SAMPLES)) begin
      base_sum_next   = sum_cur + 19'(sample);
      base_count_next = bcount_cur + 1'b1;
      // Divide by 64 truncating toward zero: bias negatives before shifting
      sum_adj = base_sum_next + {13'b0, {abts_pkg::BASE_SHIFT{base_sum_next[18]}}};
      if (base_count_next == 7'(abts_pkg::BASE_SAMPLES)) begin
        base_level_next = sum_adj[abts_pkg::BASE_SHIFT +: 12];
      end
    end else begin
      corrected = {sample[11], sample} - {level_cur[11], level_cur};
    end
  end

  // Compare against +threshold and -threshold
  always_comb begin
    corr_ext = {corrected[abts_pkg::CORR_W-1], corrected};
    thr_pos  = $signed({2'b0, threshold});
    thr_neg  = 14'sd0 - thr_pos;
    res.trig_pos  = corr_ext >= thr_pos;
    res.trig_neg  = corr_ext <= thr_neg;
    res.corrected = corrected;
    res.ready     = base_count_next == 7'(abts_pkg::BASE_SAMPLES);
    res.count     = sample_count_next;
  end

  // Hold state between samples
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      base_count   <= '0;
      base_sum     <= '0;
      base_level   <= '0;
    end else if (step) begin
      sample_count <= sample_count_next;
      base_count   <= base_count_next;
      base_sum     <= base_sum_next;
      base_level   <= base_level_next;
    end
  end

endmodule

/* hw/rtl/abts_peak.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abts_peak: window tracking
// Inside the sample window, tracks the positive and negative peaks, the
// sticky keep flag and the position and value of the last trigger.
// ----------------------------------------------------------------------------
module abts_peak (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        restart,
  input  abts_pkg::base_res_t         base,
  input  logic [abts_pkg::CFG_W-1:0]  waveform_length,
  output abts_pkg::peak_res_t         res
);

  logic                               keep_flag;
  logic                               keep_flag_next;
  logic [11:0]                        last_position;
  logic [11:0]                        last_position_next;
  logic signed [abts_pkg::CORR_W-1:0] last_value;
  logic signed [abts_pkg::CORR_W-1:0] last_value_next;
  logic signed [abts_pkg::CORR_W-1:0] max_above;
  logic signed [abts_pkg::CORR_W-1:0] max_above_next;
  logic signed [abts_pkg::CORR_W-1:0] max_below;
  logic signed [abts_pkg::CORR_W-1:0] max_below_next;

  logic signed [13:0]                 cnt_s;
  logic signed [13:0]                 win_end;
  logic signed [13:0]                 pos_end;
  logic                               in_window;
  logic                               trig;
  logic [13:0]                        half_pos;

  // Window limits from the waveform length, compared signed
  always_comb begin
    cnt_s     = $signed({1'b0, base.count});
    win_end   = $signed({2'b0, waveform_length}) - 14'(abts_pkg::WIN_END_MARGIN);
    pos_end   = $signed({2'b0, waveform_length}) - 14'(abts_pkg::POS_END_MARGIN);
    in_window = base.ready && (cnt_s > 14'(abts_pkg::WIN_START)) && (cnt_s <= win_end);
    trig      = base.trig_pos || base.trig_neg;
    half_pos  = (({1'b0, base.count} + 14'd1) >> 1) + 14'd1;
  end

  // Update peaks and trigger record
  always_comb begin
    keep_flag_next     = restart ? 1'b0 : keep_flag;
    last_position_next = restart ? '0 : last_position;
    last_value_next    = restart ? '0 : last_value;
    max_above_next     = restart ? '0 : max_above;
    max_below_next     = restart ? '0 : max_below;
    if (in_window) begin
      if (base.corrected > max_above_next) begin
        max_above_next = base.corrected;
      end
      if (base.corrected < max_below_next) begin
        max_below_next = base.corrected;
      end
      if (trig) begin
        keep_flag_next = 1'b1;
        if (cnt_s < pos_end) begin
          last_position_next = half_pos[11:0];
          last_value_next    = base.corrected;
        end
      end
    end
    res.keep          = keep_flag_next;
    res.keep_position = last_position_next;
    res.keep_value    = last_value_next;
    res.peak_pos      = max_above_next[11:0];
    res.peak_neg      = max_below_next;
  end

  // Hold state between samples
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_flag     <= 1'b0;
      last_position <= '0;
      last_value    <= '0;
      max_above     <= '0;
      max_below     <= '0;
    end else if (step) begin
      keep_flag     <= keep_flag_next;
      last_position <= last_position_next;
      last_value    <= last_value_next;
      max_above     <= max_above_next;
      max_below     <= max_below_next;
    end
  end

endmodule

/* hw/rtl/adc_baseline_threshold_suppress.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_baseline_threshold_suppress: baseline subtraction and threshold trigger
// Samples enter on the s_ stream, one result per sample leaves on m_.
//
// Usage:
//   s_tdata carries a signed 12-bit ADC sample, s_tuser[0] a restart flag
//   that clears the baseline and window state before that sample.
//   The first 64 samples after reset or restart build the baseline; their
//   corrected value is zero. Later samples are corrected and compared
//   against +/- threshold; peaks and the last trigger are tracked inside
//   the window set by waveform_length.
//   Registers are written through cfg_we / cfg_index / cfg_data while idle.
// Pipeline and throughput:
//   A sample passes the input register, then the result register, onto m_.
//   One sample per cycle is sustained while m_tready is high; all per-sample
//   work sits between the input register and the result register.
// Reset and stalls:
//   rst clears the pipeline, state and registers. While m_tready is low the
//   result register holds; the input register still takes one more sample,
//   then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module adc_baseline_threshold_suppress (
  input  logic                           clk,
  input  logic                           rst,
  // Input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // [11:0] sample
  input  logic [0:0]                     s_tuser,   // [0] restart
  // Result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] trigger, [1] trigger_pos, [2] trigger_neg, [15:3] corrected,
  // [16] ready_res, [17] keep, [29:18] keep_position, [42:30] keep_value,
  // [54:43] peak_pos, [67:55] peak_neg, [71:68] zero
  output logic [abts_pkg::OUT_W-1:0]     m_tdata,
  // Configuration write port
  input  logic                           cfg_we,
  input  logic [0:0]                     cfg_index,
  input  logic [abts_pkg::CFG_W-1:0]     cfg_data
);

  logic [abts_pkg::CFG_W-1:0]            threshold;
  logic [abts_pkg::CFG_W-1:0]            waveform_length;

  logic                                  in_valid;
  logic signed [abts_pkg::SAMPLE_W-1:0]  in_sample;
  logic                                  in_restart;
  logic                                  out_valid;
  logic [abts_pkg::OUT_W-1:0]            out_data;
  logic                                  advance;

  abts_pkg::base_res_t                   base_res;
  abts_pkg::peak_res_t                   peak_res;

  // Move the held sample to the result register when it is free
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= '0;
      waveform_length <= '0;
    end else if (cfg_we) begin
      unique case (abts_pkg::cfg_reg_t'(cfg_index))
        abts_pkg::REG_THRESHOLD:       threshold       <= cfg_data;
        abts_pkg::REG_WAVEFORM_LENGTH: waveform_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample  <= $signed(s_tdata[abts_pkg::SAMPLE_W-1:0]);
      in_restart <= s_tuser[0];
    end
  end

  abts_base u_base (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .restart   (in_restart),
    .sample    (in_sample),
    .threshold (threshold),
    .res       (base_res)
  );

  abts_peak u_peak (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .restart         (in_restart),
    .base            (base_res),
    .waveform_length (waveform_length),
    .res             (peak_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'b0,
                   peak_res.peak_neg,
                   peak_res.peak_pos,
                   peak_res.keep_value,
                   peak_res.keep_position,
                   peak_res.keep,
                   base_res.ready,
                   base_res.corrected,
                   base_res.trig_neg,
                   base_res.trig_pos,
                   base_res.trig_pos || base_res.trig_neg};
    end
  end

  // Trigger is the OR of both polarities
  a_trig_or: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[1] || m_tdata[2])))
    else $error("trigger differs from trigger_pos | trigger_neg");

  // Corrected value is zero until the baseline is ready
  a_corr_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[16]) |-> (m_tdata[15:3] == 13'd0))
    else $error("nonzero corrected value before baseline ready");

  // Negative peak never rises above zero
  a_peak_neg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67] || (m_tdata[67:55] == 13'd0)))
    else $error("peak_neg above zero");

  // Input stalls only when both pipeline registers are full and blocked
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled with room in the pipeline");

endmodule
